// File: src/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the bitmap block allocator
// Command and status codes, controller states, result record and the
// width helpers that follow from the bitmap geometry.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Default geometry
    localparam int DEF_MAX_BLOCKS = 4096;
    localparam int DEF_WORD_BITS  = 32;
    localparam int DEF_NUM_WORDS  = (DEF_MAX_BLOCKS + DEF_WORD_BITS - 1) / DEF_WORD_BITS;

    // Fixed field widths
    localparam int CFG_W = 13;
    localparam int IDX_W = 12;

    // Block count after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_OUT_OF_BLOCKS = 2'd1,
        ST_DOUBLE_FREE   = 2'd2,
        ST_OUT_OF_RANGE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0] result_index;
        status_t          status;
    } result_t;

    // Word address width, at least one bit
    function automatic int addr_width(input int n_words);
        return (n_words > 1) ? $clog2(n_words) : 1;
    endfunction

    // Width of block counts and word bases, with headroom for one word past
    // the end and for the 13-bit configured count
    function automatic int cnt_width(input int max_blocks, input int word_bits);
        int w;
        w = $clog2(max_blocks + 2 * word_bits);
        if (w < CFG_W)
            w = CFG_W;
        return w + 1;
    endfunction

endpackage

// File: src/bba_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_mem: bitmap word store
// Single write port, single read port, registered read data. The read data
// register holds its value in cycles without a read.
// ----------------------------------------------------------------------------
module bba_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int AW    = 7
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

// File: src/bba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl: allocator sequencer
// Clears the bitmap after reset, then walks the bitmap one word per cycle
// for each item: allocate looks for the lowest clear bit below the limit,
// free walks to the word that holds the block. The word is modified and
// written back in the cycle that the result is handed over.
// ----------------------------------------------------------------------------
module bba_ctrl #(
    parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
    parameter int WORD_BITS  = bba_pkg::DEF_WORD_BITS,
    parameter int NW         = bba_pkg::DEF_NUM_WORDS,
    parameter int AW         = bba_pkg::addr_width(NW),
    parameter int CW         = bba_pkg::cnt_width(MAX_BLOCKS, WORD_BITS)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  bba_pkg::cmd_t                command,
    input  logic [bba_pkg::IDX_W-1:0]    block_index,
    input  logic [CW-1:0]                limit,
    input  logic                         slot_free,
    output logic                         done,
    output bba_pkg::result_t             result,
    output logic                         wr_en,
    output logic [AW-1:0]                wr_addr,
    output logic [WORD_BITS-1:0]         wr_data,
    output logic                         rd_en,
    output logic [AW-1:0]                rd_addr,
    input  logic [WORD_BITS-1:0]         rd_data
);

    import bba_pkg::*;

    localparam int SH_W = $clog2(WORD_BITS);
    localparam logic [AW-1:0] LAST_WORD = AW'(NW - 1);

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [AW-1:0]        word_reg, word_next;
    logic [CW-1:0]        base_reg, base_next;
    logic [AW-1:0]        chk_word_reg, chk_word_next;
    logic [CW-1:0]        chk_base_reg, chk_base_next;
    logic                 chk_vld_reg, chk_vld_next;

    logic [CW-1:0]        idx_ext;
    logic                 oor;
    logic                 issue;
    logic [CW-1:0]        rem;
    logic                 in_word;
    logic [SH_W-1:0]      off;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] free_vec;
    logic                 found;
    logic [SH_W-1:0]      pos;
    logic                 finish;
    logic                 fin_wr;
    logic [WORD_BITS-1:0] fin_wdata;
    result_t              fin_res;

    // Word evaluation
    assign idx_ext  = CW'(idx_reg);
    assign oor      = (idx_ext >= limit);
    assign issue    = (base_reg < limit);
    assign rem      = limit - chk_base_reg;
    assign in_word  = (idx_ext < chk_base_reg + CW'(WORD_BITS));
    assign off      = SH_W'(idx_ext - chk_base_reg);
    assign free_vec = ~rd_data & mask;
    assign found    = |free_vec;

    // Bits of the checked word that lie below the limit
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
            mask[i] = (CW'(i) < rem);
    end

    // Lowest free bit
    always_comb
    begin
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_vec[i])
                pos = SH_W'(i);
        end
    end

    // Completion decision
    always_comb
    begin
        finish                = 1'b0;
        fin_wr                = 1'b0;
        fin_wdata             = rd_data;
        fin_res.result_index  = '0;
        fin_res.status        = ST_OK;
        if (cmd_reg == CMD_FREE)
        begin
            if (oor)
            begin
                finish         = 1'b1;
                fin_res.status = ST_OUT_OF_RANGE;
            end
            else if (chk_vld_reg && in_word)
            begin
                finish = 1'b1;
                if (rd_data[off])
                begin
                    fin_wr    = 1'b1;
                    fin_wdata = rd_data & ~(WORD_BITS'(1) << off);
                end
                else
                    fin_res.status = ST_DOUBLE_FREE;
            end
        end
        else
        begin
            if (chk_vld_reg && found)
            begin
                finish               = 1'b1;
                fin_wr               = 1'b1;
                fin_wdata            = rd_data | (WORD_BITS'(1) << pos);
                fin_res.result_index = IDX_W'(chk_base_reg + CW'(pos));
            end
            else if (!chk_vld_reg && !issue)
            begin
                finish         = 1'b1;
                fin_res.status = ST_OUT_OF_BLOCKS;
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (word_reg == LAST_WORD)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (finish && slot_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_CLEAR;
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        in_ready      = 1'b0;
        done          = 1'b0;
        result        = fin_res;
        wr_en         = 1'b0;
        wr_addr       = chk_word_reg;
        wr_data       = fin_wdata;
        rd_en         = 1'b0;
        rd_addr       = word_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        word_next     = word_reg;
        base_next     = base_reg;
        chk_word_next = chk_word_reg;
        chk_base_next = chk_base_reg;
        chk_vld_next  = chk_vld_reg;
        case (state_reg)
            S_CLEAR:
            begin
                wr_en     = 1'b1;
                wr_addr   = word_reg;
                wr_data   = '0;
                word_next = (word_reg == LAST_WORD) ? '0 : word_reg + AW'(1);
            end
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd_next     = command;
                idx_next     = block_index;
                word_next    = '0;
                base_next    = '0;
                chk_vld_next = 1'b0;
            end
            S_SCAN:
            begin
                if (finish)
                begin
                    // Hold everything while the output slot is taken
                    if (slot_free)
                    begin
                        done         = 1'b1;
                        wr_en        = fin_wr;
                        chk_vld_next = 1'b0;
                    end
                end
                else
                begin
                    rd_en         = issue;
                    chk_word_next = word_reg;
                    chk_base_next = base_reg;
                    chk_vld_next  = issue;
                    if (issue)
                    begin
                        word_next = word_reg + AW'(1);
                        base_next = base_reg + CW'(WORD_BITS);
                    end
                end
            end
            default:
            begin
                chk_vld_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            word_reg    <= '0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            word_reg    <= word_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    // Item and scan position registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        base_reg     <= base_next;
        chk_word_reg <= chk_word_next;
        chk_base_reg <= chk_base_next;
    end

`ifndef NO_ASSERTIONS
    // A write-back never overlaps a read of the next word
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg == S_SCAN) |-> !rd_en)
        else $error("bba_ctrl: read issued in write-back cycle");

    // Reads stay inside the bitmap
    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (rd_addr <= LAST_WORD))
        else $error("bba_ctrl: read beyond last bitmap word");

    // A finished item returns the sequencer to idle
    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (state_reg == S_IDLE && !chk_vld_reg))
        else $error("bba_ctrl: sequencer not idle after result");

    // A stalled result keeps the checked word steady
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && finish && !slot_free) |=> $stable(rd_data))
        else $error("bba_ctrl: checked word changed during stall");
`endif

endmodule

// File: src/bitmap_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator: first-fit bitmap block allocator
// Allocates the lowest free block below the configured count, frees a given
// block, and reports out of blocks, double free and out of range.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  input     in_valid/in_ready, command, block_index   in
//  output    out_valid/out_ready, result_index, status out
//  config    cfg_wr_en, cfg_wr_data                    in, write only
//
//  After reset a clearing pass writes every bitmap word, one per cycle
//  (NUM_WORDS words, 128 with the defaults); no item is accepted meanwhile.
//  An item walks the bitmap one word per cycle through the single read port;
//  allocate reads up to the word of the block found, or every word below the
//  count when none is free (no word for a count of zero); free reads up to
//  the word that holds the block; out of range reads no word.
//  The result waits in an output register; a new item is accepted meanwhile
//  and its scan stalls at completion until the register is taken.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
    parameter int WORD_BITS  = bba_pkg::DEF_WORD_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       command,
    input  logic [bba_pkg::IDX_W-1:0]  block_index,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [bba_pkg::IDX_W-1:0]  result_index,
    output logic [1:0]                 status,
    input  logic                       cfg_wr_en,
    input  logic [bba_pkg::CFG_W-1:0]  cfg_wr_data
);

    import bba_pkg::*;

    localparam int NW = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW = addr_width(NW);
    localparam int CW = cnt_width(MAX_BLOCKS, WORD_BITS);

    logic [CFG_W-1:0]     total_blocks_reg, total_blocks_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              res_reg, res_next;

    logic [CW-1:0]        limit;
    logic                 slot_free;
    logic                 done;
    result_t              result;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;

    // Block count register; the limit taken from it is saturated to capacity
    assign total_blocks_next = cfg_wr_en ? cfg_wr_data : total_blocks_reg;
    assign limit = (CW'(total_blocks_reg) > CW'(MAX_BLOCKS)) ?
                   CW'(MAX_BLOCKS) : CW'(total_blocks_reg);

    // Output register
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
            res_next       = result;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_blocks_reg <= CFG_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            total_blocks_reg <= total_blocks_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_index = res_reg.result_index;
    assign status       = res_reg.status;

    // Sequencer
    bba_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .WORD_BITS  (WORD_BITS),
        .NW         (NW),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (cmd_t'(command)),
        .block_index (block_index),
        .limit       (limit),
        .slot_free   (slot_free),
        .done        (done),
        .result      (result),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    // Bitmap store
    bba_mem #(
        .DEPTH (NW),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
